// ===== hw/rtl/sfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sfu_pkg;

	localparam int COMP_W = 20;
	localparam int FRAC_W = 8;
	localparam int CFG_W = 19;
	localparam int D_W = COMP_W + 2;
	localparam int MAG_W = COMP_W + 1;
	localparam int SQ_W = 2 * MAG_W + 1;
	localparam int L2_W = SQ_W + 1;
	localparam int RAD_W = L2_W + 2 * FRAC_W;
	localparam int ROOT_W = RAD_W / 2;
	localparam int MUL_W = CFG_W + FRAC_W;
	localparam int PROD_W = MAG_W + MUL_W;
	localparam int NUM_W = PROD_W + 3;
	localparam int DEN_W = ROOT_W + 1;
	localparam int Q_W = COMP_W;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES = Q_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int COMP_MAX = (1 << (COMP_W - 1)) - 1;
	localparam int COMP_MIN = -COMP_MAX - 1;

	localparam logic [2:0] ACT_SEEK = 3'd0;
	localparam logic [2:0] ACT_FLEE = 3'd1;
	localparam logic [2:0] ACT_PURSUIT = 3'd2;
	localparam logic [2:0] ACT_EVADE = 3'd3;
	localparam logic [2:0] ACT_ARRIVAL = 3'd4;

	localparam logic REG_MAX_SPEED = 1'b0;
	localparam logic REG_SLOWING_DISTANCE = 1'b1;

	localparam logic [CFG_W-1:0] MAX_SPEED_RST = 19'd2560;
	localparam logic [CFG_W-1:0] SLOWING_DISTANCE_RST = 19'd1280;

	typedef struct packed {
		logic [2:0]            action;
		logic [3*COMP_W-1:0]   target_pos;
		logic [3*COMP_W-1:0]   target_vel;
		logic [3*COMP_W-1:0]   agent_pos;
		logic [3*COMP_W-1:0]   agent_vel;
	} sfu_item_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] force_x;
		logic signed [COMP_W-1:0] force_y;
		logic signed [COMP_W-1:0] force_z;
		logic                     force_valid;
	} sfu_result_t;

	typedef struct packed {
		logic                     bad;
		logic                     arrival;
		logic [2:0][D_W-1:0]      d;
		logic [2:0][COMP_W-1:0]   vel;
	} sfu_entry_t;

	typedef struct packed {
		logic                     drop;
		logic                     ramp;
		logic                     zero;
		logic [2:0]               neg;
		logic [2:0][MAG_W-1:0]    mag;
		logic [2:0][COMP_W-1:0]   vel;
	} sfu_side_t;

	function automatic logic signed [COMP_W-1:0] lane(input logic [3*COMP_W-1:0] v,
			input int k);
		return $signed(v[k*COMP_W +: COMP_W]);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sfu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfu_front import sfu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  sfu_item_t  item,
	output logic       push,
	output sfu_entry_t entry,
	input  logic       full
);

	logic       v_s1;
	sfu_entry_t entry_s1;
	sfu_entry_t nxt;
	logic       accept;

	always_comb begin
		logic signed [D_W-1:0] t;
		logic signed [D_W-1:0] p;
		nxt = '0;
		nxt.bad = item.action > ACT_ARRIVAL;
		nxt.arrival = item.action == ACT_ARRIVAL;
		for (int k = 0; k < 3; k++) begin
			t = D_W'(lane(item.target_pos, k));
			p = D_W'(lane(item.agent_pos, k));
			if (item.action == ACT_PURSUIT || item.action == ACT_EVADE) begin
				t = t + D_W'(lane(item.target_vel, k));
			end
			if (item.action == ACT_FLEE || item.action == ACT_EVADE) begin
				nxt.d[k] = p - t;
			end else begin
				nxt.d[k] = t - p;
			end
			nxt.vel[k] = item.agent_vel[k*COMP_W +: COMP_W];
		end
	end

	assign item_stall = v_s1 && full;
	assign accept = item_valid && !item_stall;
	assign push = v_s1 && !full;
	assign entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sfu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfu_queue import sfu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sfu_entry_t wr_entry,
	output logic       full,
	input  logic       pop,
	output sfu_entry_t rd_entry,
	output logic       empty
);

	sfu_entry_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rd_entry = slot_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sfu_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfu_div import sfu_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	logic [NUM_W-1:0] rem_s [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES];
	logic [Q_W-1:0]   quo_s [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		localparam int B = Q_W - 1 - j;
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in;
		logic [NUM_W-1:0] sub;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		assign sub = NUM_W'(den_in) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= den_in;
				if (rem_in >= sub) begin
					rem_s[j] <= rem_in - sub;
					quo_s[j] <= quo_in | (Q_W'(1) << B);
				end else begin
					rem_s[j] <= rem_in;
					quo_s[j] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/sfu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfu_back import sfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	output logic             pop,
	input  sfu_entry_t       head,
	input  logic [CFG_W-1:0] speed,
	input  logic [CFG_W-1:0] slow,
	output logic             result_valid,
	input  logic             result_stall,
	output sfu_result_t      result
);

	logic                  en;
	logic [CFG_W-1:0]      slow_eff;
	logic [2*CFG_W-1:0]    slow_sq_q;

	logic                  v_s1;
	logic                  bad_s1;
	logic                  arrival_s1;
	logic [2:0]            neg_s1;
	logic [2:0][MAG_W-1:0] mag_s1;
	logic [2:0][SQ_W-1:0]  sq_s1;
	logic [2:0][COMP_W-1:0] vel_s1;

	logic                  v_s2;
	sfu_side_t             side_s2;
	logic [RAD_W-1:0]      rad_s2;
	logic [L2_W-1:0]       l2;

	logic                  sq_v_s [SQRT_STAGES];
	logic [RAD_W-1:0]      rem_s [SQRT_STAGES];
	logic [ROOT_W-1:0]     root_s [SQRT_STAGES];
	sfu_side_t             sq_side_s [SQRT_STAGES];

	logic                  v_s3;
	sfu_side_t             side_s3;
	logic [2:0][PROD_W-1:0] prod_s3;
	logic [ROOT_W-1:0]     den_s3;
	logic [ROOT_W-1:0]     den_sel;
	logic [MUL_W-1:0]      mul_sel;

	logic                  v_s4;
	sfu_side_t             side_s4;
	logic [2:0][NUM_W-1:0] num_s4;
	logic [DEN_W-1:0]      den2_s4;

	logic                  dv_v_s [DIV_STAGES];
	sfu_side_t             dv_side_s [DIV_STAGES];
	logic [2:0][Q_W-1:0]   quo;

	logic                  result_valid_q;
	sfu_result_t           result_q;
	sfu_result_t           res_nxt;
	sfu_side_t             side_out;

	assign en = !result_valid_q || !result_stall;
	assign pop = en && !empty;
	assign slow_eff = (slow == '0) ? CFG_W'(1) : slow;

	always_ff @(posedge clk) begin
		slow_sq_q <= (2*CFG_W)'(slow_eff) * (2*CFG_W)'(slow_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= sq_v_s[SQRT_STAGES-1];
			v_s4 <= v_s3;
			result_valid_q <= dv_v_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s1 <= head.bad;
			arrival_s1 <= head.arrival;
			vel_s1 <= head.vel;
			for (int k = 0; k < 3; k++) begin
				neg_s1[k] <= head.d[k][D_W-1];
				mag_s1[k] <= MAG_W'(head.d[k][D_W-1] ? -head.d[k] : head.d[k]);
				sq_s1[k] <= SQ_W'(MAG_W'(head.d[k][D_W-1] ? -head.d[k] : head.d[k]))
					* SQ_W'(MAG_W'(head.d[k][D_W-1] ? -head.d[k] : head.d[k]));
			end
		end
	end

	assign l2 = L2_W'(sq_s1[0]) + L2_W'(sq_s1[1]) + L2_W'(sq_s1[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.zero <= l2 == '0;
			side_s2.drop <= bad_s1 || (arrival_s1 && l2 == '0);
			side_s2.ramp <= arrival_s1 && (l2 < L2_W'(slow_sq_q));
			side_s2.neg <= neg_s1;
			side_s2.mag <= mag_s1;
			side_s2.vel <= vel_s1;
			rad_s2 <= RAD_W'(l2) << (2 * FRAC_W);
		end
	end

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - j;
		logic              v_in;
		logic [RAD_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		sfu_side_t         side_in;
		logic [RAD_W-1:0]  trial;

		if (j == 0) begin : g_first
			assign v_in = v_s2;
			assign rem_in = rad_s2;
			assign root_in = '0;
			assign side_in = side_s2;
		end else begin : g_next
			assign v_in = sq_v_s[j-1];
			assign rem_in = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign side_in = sq_side_s[j-1];
		end

		assign trial = (RAD_W'(root_in) << (B + 1)) | (RAD_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j] <= 1'b0;
			end else if (en) begin
				sq_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side_s[j] <= side_in;
				if (rem_in >= trial) begin
					rem_s[j] <= rem_in - trial;
					root_s[j] <= root_in | (ROOT_W'(1) << B);
				end else begin
					rem_s[j] <= rem_in;
					root_s[j] <= root_in;
				end
			end
		end
	end

	always_comb begin
		if (sq_side_s[SQRT_STAGES-1].ramp) begin
			den_sel = ROOT_W'(slow_eff);
			mul_sel = MUL_W'(speed);
		end else begin
			den_sel = root_s[SQRT_STAGES-1];
			mul_sel = MUL_W'(speed) << FRAC_W;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= sq_side_s[SQRT_STAGES-1];
			den_s3 <= den_sel;
			for (int k = 0; k < 3; k++) begin
				prod_s3[k] <= PROD_W'(sq_side_s[SQRT_STAGES-1].mag[k]) * PROD_W'(mul_sel);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			den2_s4 <= DEN_W'(den_s3) << 1;
			for (int k = 0; k < 3; k++) begin
				num_s4[k] <= (NUM_W'(prod_s3[k]) << 1) + NUM_W'(den_s3);
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		sfu_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s4[k]),
			.den (den2_s4),
			.quo (quo[k])
		);
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_side
		if (j == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[j] <= 1'b0;
				end else if (en) begin
					dv_v_s[j] <= v_s4;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					dv_side_s[j] <= side_s4;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[j] <= 1'b0;
				end else if (en) begin
					dv_v_s[j] <= dv_v_s[j-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					dv_side_s[j] <= dv_side_s[j-1];
				end
			end
		end
	end

	assign side_out = dv_side_s[DIV_STAGES-1];

	always_comb begin
		logic signed [D_W-1:0] qs;
		logic signed [D_W-1:0] diff;
		logic signed [D_W-1:0] f [3];
		for (int k = 0; k < 3; k++) begin
			qs = $signed(D_W'(quo[k]));
			if (side_out.zero) begin
				qs = '0;
			end else if (side_out.neg[k]) begin
				qs = -qs;
			end
			diff = qs - D_W'($signed(side_out.vel[k]));
			if (diff > D_W'(COMP_MAX)) begin
				f[k] = D_W'(COMP_MAX);
			end else if (diff < D_W'(COMP_MIN)) begin
				f[k] = D_W'(COMP_MIN);
			end else begin
				f[k] = diff;
			end
		end
		res_nxt.force_x = COMP_W'(f[0]);
		res_nxt.force_y = COMP_W'(f[1]);
		res_nxt.force_z = COMP_W'(f[2]);
		res_nxt.force_valid = 1'b1;
		if (side_out.drop) begin
			res_nxt = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[SQRT_STAGES-1] && !sq_side_s[SQRT_STAGES-1].zero
		|-> root_s[SQRT_STAGES-1] >= (ROOT_W'(1) << FRAC_W))
		else $error("root below one unit for nonzero vector");
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[DIV_STAGES-1] && !side_out.zero
		|-> quo[0] <= (Q_W'(1) << (COMP_W - 1)) && quo[1] <= (Q_W'(1) << (COMP_W - 1))
			&& quo[2] <= (Q_W'(1) << (COMP_W - 1)))
		else $error("desired speed exceeds range");
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.force_valid
		|-> result_q.force_x == '0 && result_q.force_y == '0 && result_q.force_z == '0)
		else $error("dropped result carries a force");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/steering_force_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Steering force unit: one seek, flee, pursuit, evade or arrival force per transaction,
// Q12.8 per component. It takes a new item every cycle unless item_stall is high (an item
// waits in the front register and the queue is full) and returns one result per item in
// order. Results pass the fully pipelined square root (one root bit per stage, 30 stages)
// and the three pipelined dividers (one quotient bit per stage, 20 stages). A four-entry
// queue sits between the decode front and the arithmetic pipeline. Write max_speed and
// slowing_distance only while no transaction is in flight; cfg_ready is always high.
module steering_force_unit import sfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sfu_item_t        item,
	output logic             result_valid,
	input  logic             result_stall,
	output sfu_result_t      result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] max_speed_q;
	logic [CFG_W-1:0] slowing_distance_q;
	logic             push;
	logic             full;
	logic             empty;
	logic             pop;
	sfu_entry_t       wr_entry;
	sfu_entry_t       rd_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			slowing_distance_q <= SLOWING_DISTANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_SPEED: max_speed_q <= cfg_data;
				REG_SLOWING_DISTANCE: slowing_distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sfu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.entry      (wr_entry),
		.full       (full)
	);

	sfu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.rd_entry (rd_entry),
		.empty    (empty)
	);

	sfu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop          (pop),
		.head         (rd_entry),
		.speed        (max_speed_q),
		.slow         (slowing_distance_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== bench/steering_force_unit_tb.sv =====
`timescale 1ns / 1ps
module steering_force_unit_tb;
	import sfu_pkg::*;

	localparam logic [2:0] ACT_SPARE = 3'd7;
	localparam int PHASE_ITEMS = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		logic [2:0]          act;
		logic [3*COMP_W-1:0] tp;
		logic [3*COMP_W-1:0] tv;
		logic [3*COMP_W-1:0] ap;
		logic [3*COMP_W-1:0] av;
		bit                  typed;
		sfu_result_t         res;
	} steer_row_t;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	sfu_item_t        item;
	logic             result_valid;
	logic             result_stall;
	sfu_result_t      result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	logic [CFG_W-1:0] speed_reg;
	logic [CFG_W-1:0] slow_reg;
	sfu_result_t      pending_forces[$];
	steer_row_t       rows[$];
	int               mismatches;
	bit               quiet;
	bit               hold_req;

	steering_force_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint signed ratio_round(input longint signed num,
			input longint unsigned mul, input longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = (mag * mul * 2 + den) / (den * 2);
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint signed comp(input logic [3*COMP_W-1:0] v, input int k);
		logic signed [COMP_W-1:0] c;
		c = v[k*COMP_W +: COMP_W];
		return longint'(c);
	endfunction

	function automatic sfu_result_t steer_force(input sfu_item_t it);
		sfu_result_t r;
		longint signed d[3];
		longint signed want[3];
		longint signed t;
		longint signed f;
		longint unsigned l2;
		longint unsigned len;
		longint unsigned spd;
		longint unsigned slw;
		spd = speed_reg;
		slw = (slow_reg == 0) ? 1 : slow_reg;
		r = '0;
		l2 = 0;
		if (it.action > ACT_ARRIVAL)
			return r;
		for (int k = 0; k < 3; k++) begin
			t = comp(it.target_pos, k);
			if (it.action == ACT_PURSUIT || it.action == ACT_EVADE)
				t = t + comp(it.target_vel, k);
			d[k] = (it.action == ACT_FLEE || it.action == ACT_EVADE) ?
				comp(it.agent_pos, k) - t : t - comp(it.agent_pos, k);
			l2 = l2 + longint'(d[k] * d[k]);
		end
		if (it.action == ACT_ARRIVAL && l2 == 0)
			return r;
		len = root_floor(l2 << 16);
		for (int k = 0; k < 3; k++) begin
			if (l2 == 0)
				want[k] = 0;
			else if (it.action == ACT_ARRIVAL && l2 < slw * slw)
				want[k] = ratio_round(d[k], spd, slw);
			else
				want[k] = ratio_round(d[k], spd << 8, len);
			f = want[k] - comp(it.agent_vel, k);
			if (f > COMP_MAX)
				f = COMP_MAX;
			if (f < COMP_MIN)
				f = COMP_MIN;
			if (k == 0)
				r.force_x = f[COMP_W-1:0];
			else if (k == 1)
				r.force_y = f[COMP_W-1:0];
			else
				r.force_z = f[COMP_W-1:0];
		end
		r.force_valid = 1'b1;
		return r;
	endfunction

	function automatic logic [3*COMP_W-1:0] vec3(input int x, input int y, input int z);
		logic [COMP_W-1:0] a;
		logic [COMP_W-1:0] b;
		logic [COMP_W-1:0] c;
		a = x[COMP_W-1:0];
		b = y[COMP_W-1:0];
		c = z[COMP_W-1:0];
		return {c, b, a};
	endfunction

	function automatic int rand_comp();
		case ($urandom_range(3))
			0: return $signed($urandom_range(0, (1 << COMP_W) - 1) << (32 - COMP_W))
				>>> (32 - COMP_W);
			1: return int'($urandom_range(0, 4095)) - 2048;
			2: begin
				case ($urandom_range(3))
					0: return COMP_MAX;
					1: return COMP_MIN;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic logic [3*COMP_W-1:0] rand_vec();
		return vec3(rand_comp(), rand_comp(), rand_comp());
	endfunction

	task automatic add_row(input logic [2:0] act, input logic [3*COMP_W-1:0] tp,
			input logic [3*COMP_W-1:0] tv, input logic [3*COMP_W-1:0] ap,
			input logic [3*COMP_W-1:0] av, input bit typed, input sfu_result_t res);
		steer_row_t r;
		r.act = act;
		r.tp = tp;
		r.tv = tv;
		r.ap = ap;
		r.av = av;
		r.typed = typed;
		r.res = res;
		rows.push_back(r);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MAX_SPEED)
			speed_reg = val;
		else
			slow_reg = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_item(input sfu_item_t it, input bit typed, input sfu_result_t res);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 10) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item = it;
		do @(posedge clk); while (item_stall);
		pending_forces.push_back(typed ? res : steer_force(it));
	endtask

	task automatic end_items();
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic send_random();
		sfu_item_t it;
		sfu_result_t none;
		none = '0;
		it.action = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) :
			3'($urandom_range(0, 4));
		it.target_pos = rand_vec();
		it.target_vel = rand_vec();
		it.agent_pos = ($urandom_range(9) == 0) ? it.target_pos : rand_vec();
		it.agent_vel = rand_vec();
		if ($urandom_range(3) == 0)
			it.agent_pos = it.target_pos ^ vec3($urandom_range(3), $urandom_range(3),
				$urandom_range(3));
		send_item(it, 1'b0, none);
	endtask

	always @(posedge clk) begin
		sfu_result_t want;
		if (result_valid && !result_stall) begin
			if (pending_forces.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: %p", result);
			end else begin
				want = pending_forces.pop_front();
				if (result.force_x !== want.force_x || result.force_y !== want.force_y ||
						result.force_z !== want.force_z ||
						result.force_valid !== want.force_valid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d v%0b, got %0d %0d %0d v%0b",
							want.force_x, want.force_y, want.force_z, want.force_valid,
							result.force_x, result.force_y, result.force_z,
							result.force_valid);
				end
			end
		end
	end

	initial begin
		int held;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				held = 0;
				while (held < HOLD_CYCLES) begin
					result_stall = 1'b1;
					@(negedge clk);
					held++;
				end
				hold_req = 1'b0;
			end
			result_stall = !quiet && ($urandom_range(99) < 10);
		end
	end

	initial begin
		sfu_result_t none;
		sfu_result_t r0;
		sfu_result_t rsat;
		sfu_item_t it;
		logic [CFG_W-1:0] speeds[5];
		logic [CFG_W-1:0] slows[5];
		int waited;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_SPEED;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		mismatches = 0;
		speed_reg = MAX_SPEED_RST;
		slow_reg = SLOWING_DISTANCE_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		none = '0;
		r0 = '0;
		r0.force_valid = 1'b1;
		rsat = '{force_x: COMP_MAX, force_y: COMP_MAX, force_z: COMP_MAX, force_valid: 1'b1};
		add_row(ACT_SEEK, '0, '0, '0, '0, 1'b1, r0);
		add_row(ACT_ARRIVAL, vec3(5, -7, 9), '0, vec3(5, -7, 9), vec3(3, 3, 3), 1'b1, none);
		add_row(ACT_SPARE, '1, '1, '0, '1, 1'b1, none);
		add_row(3'd5, vec3(100, 0, 0), '0, '0, '0, 1'b1, none);
		add_row(3'd6, vec3(100, 0, 0), '0, '0, '0, 1'b1, none);
		add_row(ACT_SEEK, vec3(7, 7, 7), '0, vec3(7, 7, 7),
			vec3(COMP_MIN, COMP_MIN, COMP_MIN), 1'b1, rsat);
		add_row(ACT_FLEE, vec3(9, 9, 9), '0, vec3(9, 9, 9),
			vec3(COMP_MAX, COMP_MAX, COMP_MAX), 1'b1,
			'{force_x: -COMP_MAX, force_y: -COMP_MAX, force_z: -COMP_MAX, force_valid: 1'b1});
		add_row(ACT_SEEK, vec3(256, 0, 0), '0, '0, '0, 1'b0, none);
		add_row(ACT_FLEE, vec3(0, 256, 0), '0, '0, vec3(10, 20, 30), 1'b0, none);
		add_row(ACT_PURSUIT, vec3(100, 200, 300), vec3(-50, 60, -70), vec3(1, 2, 3),
			'0, 1'b0, none);
		add_row(ACT_EVADE, vec3(100, 200, 300), vec3(-50, 60, -70), vec3(1, 2, 3),
			vec3(-4, 5, -6), 1'b0, none);
		add_row(ACT_PURSUIT, vec3(COMP_MAX, COMP_MAX, COMP_MAX),
			vec3(COMP_MAX, COMP_MAX, COMP_MAX), vec3(COMP_MIN, COMP_MIN, COMP_MIN), '0,
			1'b0, none);
		add_row(ACT_EVADE, vec3(COMP_MIN, COMP_MIN, COMP_MIN),
			vec3(COMP_MIN, COMP_MIN, COMP_MIN), vec3(COMP_MAX, COMP_MAX, COMP_MAX), '1,
			1'b0, none);
		add_row(ACT_PURSUIT, vec3(10, 10, 10), vec3(-10, -10, -10), '0, vec3(1, 1, 1),
			1'b0, none);
		add_row(ACT_ARRIVAL, vec3(1, 0, 0), '0, '0, '0, 1'b0, none);
		add_row(ACT_ARRIVAL, vec3(640, 0, 0), '0, '0, '0, 1'b0, none);
		add_row(ACT_ARRIVAL, vec3(1280, 0, 0), '0, '0, '0, 1'b0, none);
		add_row(ACT_ARRIVAL, vec3(0, -1279, 0), '0, '0, vec3(5, 5, 5), 1'b0, none);
		add_row(ACT_ARRIVAL, vec3(COMP_MAX, COMP_MIN, COMP_MAX), '0,
			vec3(COMP_MIN, COMP_MAX, COMP_MIN), '0, 1'b0, none);
		add_row(ACT_SEEK, vec3(COMP_MAX, COMP_MAX, COMP_MAX), '0,
			vec3(COMP_MIN, COMP_MIN, COMP_MIN), vec3(COMP_MIN, 0, COMP_MAX), 1'b0, none);
		add_row(ACT_FLEE, vec3(1, 1, 0), '0, '0, '0, 1'b0, none);
		add_row(ACT_SEEK, vec3(-3, 0, 4), '0, '0, '0, 1'b0, none);

		foreach (rows[i]) begin
			it.action = rows[i].act;
			it.target_pos = rows[i].tp;
			it.target_vel = rows[i].tv;
			it.agent_pos = rows[i].ap;
			it.agent_vel = rows[i].av;
			send_item(it, rows[i].typed, rows[i].res);
		end
		end_items();

		speeds = '{MAX_SPEED_RST, 19'h7FFFF, 19'd0, 19'd1, 19'($urandom)};
		slows = '{SLOWING_DISTANCE_RST, 19'h7FFFF, 19'd1, 19'h7FFFF, 19'($urandom_range(1,
			(1 << CFG_W) - 1))};
		for (int ph = 0; ph < 5; ph++) begin
			wait (pending_forces.size() == 0);
			write_reg(REG_MAX_SPEED, speeds[ph]);
			write_reg(REG_SLOWING_DISTANCE, slows[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 50)
					hold_req = 1'b1;
				if (ph == 2)
					quiet = (n < 300);
				if (ph == 3 && n == 200) begin
					end_items();
					wait (pending_forces.size() == 0);
				end
				send_random();
			end
			end_items();
			quiet = 1'b0;
		end

		wait (pending_forces.size() == 0);
		waited = 0;
		while (waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
